### rtl/core/sacd_pkg.sv
// Shared types and constants for the 4-way tree-PLRU cache directory.
// No dependencies; used by set_assoc_cache_directory_plru.
package sacd_pkg;

    localparam int WAYS   = 4;
    localparam int WAY_W  = 2;
    localparam int PLRU_W = 3;
    localparam int CNT_W  = 32;
    localparam int ADDR_W = 32;

    // Access kinds
    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    // Request word: one processor access
    typedef struct packed {
        logic              action;
        logic [ADDR_W-1:0] address;
    } t_req;

    // Response word: lookup outcome plus running statistics
    typedef struct packed {
        logic             hit;
        logic             write_back;
        logic [WAY_W-1:0] way;
        logic [CNT_W-1:0] read_total;
        logic [CNT_W-1:0] write_total;
        logic [CNT_W-1:0] hit_total;
        logic [CNT_W-1:0] miss_total;
        logic [CNT_W-1:0] evict_total;
    } t_rsp;

    // Per-set bookkeeping kept in one memory word
    typedef struct packed {
        logic [PLRU_W-1:0] plru;
        logic [WAYS-1:0]   valid;
        logic [WAYS-1:0]   dirty;
    } t_set_state;

    localparam int SET_STATE_W = $bits(t_set_state);

    // Tree-PLRU victim by state: bit 2 picks the pair, bits 1/0 the way in it
    localparam logic [WAY_W-1:0] VICTIM_OF [8] = '{
        2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3
    };

    // Point the tree away from the way just referenced
    function automatic logic [PLRU_W-1:0] plru_touch(
        input logic [PLRU_W-1:0] plru,
        input logic [WAY_W-1:0]  way
    );
        logic [PLRU_W-1:0] res;
        unique case (way)
            2'd0:    res = {2'b11, plru[0]};
            2'd1:    res = {2'b10, plru[0]};
            2'd2:    res = {1'b0, plru[1], 1'b1};
            default: res = {1'b0, plru[1], 1'b0};
        endcase
        return res;
    endfunction

endpackage

### rtl/core/sacd_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sacd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, old data on a same-address write; holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/set_assoc_cache_directory_plru.sv
// Top level: 4-way write-back cache directory with tree pseudo-LRU replacement.
// Depends on sacd_pkg and sacd_ram.
//
//   channel | direction | handshake                  | word
//   --------+-----------+----------------------------+----------------------
//   request | in        | i_req_valid / o_req_ready  | i_req  (sacd_pkg::t_req)
//   response| out       | o_rsp_valid / i_rsp_ready  | o_rsp  (sacd_pkg::t_rsp)
//
// One access per cycle sustained while the response side keeps up; a taken word
// reaches o_rsp after the tag and set-state memories are read at the accepting edge
// and the compare/update is registered into the output reg.
// After reset a clearing pass zeroes the set-state memory, one set at a time, with
// o_req_ready low. Tags are not cleared; a way is compared only once it is valid.
// A stalled response holds the lookup stage; the request side stalls behind it.
// SET_COUNT must be a power of two.
module set_assoc_cache_directory_plru #(
    parameter int SET_COUNT   = 16,
    parameter int OFFSET_BITS = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  sacd_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output sacd_pkg::t_rsp o_rsp
);

    localparam int SET_BITS = $clog2(SET_COUNT);
    localparam int TAG_W    = sacd_pkg::ADDR_W - OFFSET_BITS - SET_BITS;
    localparam int WAYS     = sacd_pkg::WAYS;
    localparam int WAY_W    = sacd_pkg::WAY_W;
    localparam int CNT_W    = sacd_pkg::CNT_W;
    localparam logic [SET_BITS-1:0] LAST_SET = SET_BITS'(SET_COUNT - 1);

    // Handshake and flow control
    logic accept;
    logic out_free;
    logic s1_fire;

    // Clearing pass
    logic                r_clr_active;
    logic [SET_BITS-1:0] r_clr_idx;

    // Lookup stage registers
    logic                r_s1_valid;
    logic                r_s1_action;
    logic [SET_BITS-1:0] r_s1_set;
    logic [TAG_W-1:0]    r_s1_tag;

    // Forwarding of a write that landed at the same edge as the read
    logic                 r_st_byp;
    sacd_pkg::t_set_state r_byp_st;
    logic [WAYS-1:0]      r_tag_byp;
    logic [TAG_W-1:0]     r_byp_tag;

    // Memory interfaces
    logic [SET_BITS-1:0]  rd_set;
    logic [TAG_W-1:0]     rd_tag;
    logic [TAG_W-1:0]     tag_q [WAYS];
    logic [TAG_W-1:0]     tag_cur [WAYS];
    logic [sacd_pkg::SET_STATE_W-1:0] st_q;
    logic [sacd_pkg::SET_STATE_W-1:0] st_wdata;
    logic [SET_BITS-1:0]  st_waddr;
    logic                 st_we;
    sacd_pkg::t_set_state st_cur;
    sacd_pkg::t_set_state n_state;
    logic [WAYS-1:0]      tag_we;

    // Lookup results
    logic [WAYS-1:0]  hit_vec;
    logic             s_hit;
    logic [WAY_W-1:0] hit_way;
    logic [WAY_W-1:0] inv_way;
    logic             all_valid;
    logic [WAY_W-1:0] s_way;
    logic             s_wb;
    logic             byp_set;

    // Statistics
    logic [CNT_W-1:0] r_read_cnt, r_write_cnt, r_hit_cnt, r_miss_cnt, r_evict_cnt;
    logic [CNT_W-1:0] n_read_cnt, n_write_cnt, n_hit_cnt, n_miss_cnt, n_evict_cnt;

    // Output register
    logic           r_rsp_valid;
    sacd_pkg::t_rsp r_rsp;

    // Flow control: the lookup stage advances whenever the output reg can take a word
    assign out_free    = !r_rsp_valid || i_rsp_ready;
    assign s1_fire     = r_s1_valid && out_free;
    assign o_req_ready = !r_clr_active && (!r_s1_valid || out_free);
    assign accept      = i_req_valid && o_req_ready;

    // Address split of the incoming word
    assign rd_set = i_req.address[OFFSET_BITS +: SET_BITS];
    assign rd_tag = i_req.address[sacd_pkg::ADDR_W-1 -: TAG_W];

    // Tag memories, one per way
    for (genvar w = 0; w < WAYS; w++) begin : g_tag
        assign tag_we[w] = s1_fire && !s_hit && (s_way == WAY_W'(w));

        sacd_ram #(
            .WIDTH (TAG_W),
            .DEPTH (SET_COUNT)
        ) u_tag_ram (
            .i_clk   (i_clk),
            .i_we    (tag_we[w]),
            .i_waddr (r_s1_set),
            .i_wdata (r_s1_tag),
            .i_re    (accept),
            .i_raddr (rd_set),
            .o_rdata (tag_q[w])
        );

        assign tag_cur[w] = r_tag_byp[w] ? r_byp_tag : tag_q[w];
    end

    // Set-state memory, zeroed by the clearing pass
    assign st_we    = r_clr_active || s1_fire;
    assign st_waddr = r_clr_active ? r_clr_idx : r_s1_set;
    assign st_wdata = r_clr_active ? '0 : n_state;

    sacd_ram #(
        .WIDTH (sacd_pkg::SET_STATE_W),
        .DEPTH (SET_COUNT)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_re    (accept),
        .i_raddr (rd_set),
        .o_rdata (st_q)
    );

    assign st_cur = r_st_byp ? r_byp_st : sacd_pkg::t_set_state'(st_q);

    // Way compares and lowest-index picks
    always_comb begin
        hit_way   = '0;
        inv_way   = '0;
        all_valid = &st_cur.valid;
        for (int w = WAYS - 1; w >= 0; w--) begin
            hit_vec[w] = st_cur.valid[w] && (tag_cur[w] == r_s1_tag);
            if (hit_vec[w]) begin
                hit_way = WAY_W'(w);
            end
            if (!st_cur.valid[w]) begin
                inv_way = WAY_W'(w);
            end
        end
        s_hit = |hit_vec;
    end

    // Way selection, write-back and next set state
    always_comb begin
        priority if (s_hit) begin
            s_way = hit_way;
        end else if (!all_valid) begin
            s_way = inv_way;
        end else begin
            s_way = sacd_pkg::VICTIM_OF[st_cur.plru];
        end
        s_wb = !s_hit && st_cur.valid[s_way] && st_cur.dirty[s_way];

        n_state       = st_cur;
        n_state.plru  = sacd_pkg::plru_touch(st_cur.plru, s_way);
        n_state.valid[s_way] = 1'b1;
        if (!s_hit) begin
            n_state.dirty[s_way] = 1'b0;
        end
        if (r_s1_action == sacd_pkg::ACT_WRITE) begin
            n_state.dirty[s_way] = 1'b1;
        end
    end

    // Counter updates
    always_comb begin
        n_read_cnt  = r_read_cnt  + CNT_W'(r_s1_action == sacd_pkg::ACT_READ);
        n_write_cnt = r_write_cnt + CNT_W'(r_s1_action == sacd_pkg::ACT_WRITE);
        n_hit_cnt   = r_hit_cnt   + CNT_W'(s_hit);
        n_miss_cnt  = r_miss_cnt  + CNT_W'(!s_hit);
        n_evict_cnt = r_evict_cnt + CNT_W'(s_wb);
    end

    // Clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_idx    <= '0;
        end else if (r_clr_active) begin
            r_clr_idx <= r_clr_idx + SET_BITS'(1);
            if (r_clr_idx == LAST_SET) begin
                r_clr_active <= 1'b0;
            end
        end
    end

    // Lookup stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Lookup stage payload and same-set forwarding flags
    assign byp_set = s1_fire && (r_s1_set == rd_set);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st_byp  <= 1'b0;
            r_tag_byp <= '0;
        end else if (accept) begin
            r_st_byp <= byp_set;
            for (int w = 0; w < WAYS; w++) begin
                r_tag_byp[w] <= byp_set && tag_we[w];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_action <= i_req.action;
            r_s1_set    <= rd_set;
            r_s1_tag    <= rd_tag;
            r_byp_st    <= n_state;
            r_byp_tag   <= r_s1_tag;
        end
    end

    // Statistics counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_cnt  <= '0;
            r_write_cnt <= '0;
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_evict_cnt <= '0;
        end else if (s1_fire) begin
            r_read_cnt  <= n_read_cnt;
            r_write_cnt <= n_write_cnt;
            r_hit_cnt   <= n_hit_cnt;
            r_miss_cnt  <= n_miss_cnt;
            r_evict_cnt <= n_evict_cnt;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (out_free) begin
            r_rsp_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_rsp.hit         <= s_hit;
            r_rsp.write_back  <= s_wb;
            r_rsp.way         <= s_way;
            r_rsp.read_total  <= n_read_cnt;
            r_rsp.write_total <= n_write_cnt;
            r_rsp.hit_total   <= n_hit_cnt;
            r_rsp.miss_total  <= n_miss_cnt;
            r_rsp.evict_total <= n_evict_cnt;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

`ifndef SYNTHESIS
    // Every access is counted once as a hit or a miss and once as a read or a write
    a_count_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hit_cnt + r_miss_cnt) == (r_read_cnt + r_write_cnt))
        else $error("hit/miss totals disagree with read/write totals");

    // A write-back only comes from a miss
    a_wb_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> !(o_rsp.hit && o_rsp.write_back))
        else $error("write-back reported on a hit");

    // No eviction while the set still has a free way
    a_wb_full_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && s_wb) |-> all_valid)
        else $error("write-back with an invalid way available");

    // The chosen way is valid once the access completes
    a_way_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire |-> n_state.valid[s_way])
        else $error("used way left invalid");

    // No request is taken during the clearing pass
    a_no_accept_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_active |-> !accept && !r_s1_valid)
        else $error("access taken while set state is being cleared");
`endif

endmodule
